// ----- hw/rtl/tiex_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tiex_pkg;

   localparam int REG_COUNT     = 16;
   localparam int STACK_DEPTH   = 16;
   localparam int DMEM_DEPTH    = 4096;
   localparam int SCREEN_WIDTH  = 512;
   localparam int SCREEN_HEIGHT = 256;
   localparam int PIXEL_RUN     = 14;

   localparam int FUNC_W = 5;
   localparam int REGF_W = 4;
   localparam int IMM_W  = 32;
   localparam int PC_W   = 16;
   localparam int RND_W  = 31;
   localparam int WORD_W = 64;
   localparam int HALF_W = 32;
   localparam int PX_W   = 9;
   localparam int PY_W   = 8;
   localparam int COL_W  = 32;
   localparam int ERR_W  = 3;

   localparam int REG_AW   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int STACK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SP_W     = $clog2(STACK_DEPTH + 1);
   localparam int DMEM_AW  = $clog2(DMEM_DEPTH);
   localparam int AP_W     = $clog2(DMEM_DEPTH + 1);
   localparam int RUN_W    = (PIXEL_RUN > 1) ? $clog2(PIXEL_RUN) : 1;

   localparam int PIX_X_REG = 0;
   localparam int PIX_Y_REG = 1 % REG_COUNT;
   localparam int PIX_C_REG = 2 % REG_COUNT;

   // both queues are a power of two deep
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PW        = $clog2(QUEUE_DEPTH);
   localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

   localparam int DIV_STEPS = WORD_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS);
   localparam int MUL_LAST  = 3;

   typedef enum logic [FUNC_W-1:0] {
      OP_RET      = 5'd0,
      OP_PIXELS   = 5'd1,
      OP_FLUSH    = 5'd2,
      OP_JMP      = 5'd3,
      OP_CALL     = 5'd4,
      OP_RAND     = 5'd5,
      OP_MV       = 5'd6,
      OP_MVI      = 5'd7,
      OP_ALLOCA   = 5'd8,
      OP_ADD      = 5'd9,
      OP_SUB      = 5'd10,
      OP_DIV      = 5'd11,
      OP_OR       = 5'd12,
      OP_ADDI     = 5'd13,
      OP_MULI     = 5'd14,
      OP_REMI     = 5'd15,
      OP_ANDI     = 5'd16,
      OP_SLI      = 5'd17,
      OP_LOAD     = 5'd18,
      OP_STORE    = 5'd19,
      OP_ICMPGE   = 5'd20,
      OP_ICMPNE   = 5'd21,
      OP_CONDBR   = 5'd22
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 3'd0,
      ERR_DIV_ZERO = 3'd1,
      ERR_STACK    = 3'd2,
      ERR_MEM      = 3'd3,
      ERR_PIXEL    = 3'd4
   } err_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_MEMRD,
      ST_DONE,
      ST_PIXEL
   } state_type;

   typedef struct packed {
      op_type              op;
      logic                known;
      logic [REG_AW-1:0]   rd_idx;
      logic [REG_AW-1:0]   addr0;
      logic [REG_AW-1:0]   addr1;
      logic [REG_AW-1:0]   addr2;
      logic [WORD_W-1:0]   imm;
      logic [PC_W-1:0]     alt;
      logic [RND_W-1:0]    rnd;
   } dec_type;

   typedef struct packed {
      logic [PC_W-1:0]  next_pc;
      logic             running;
      logic             pixel_valid;
      logic [PX_W-1:0]  pixel_x;
      logic [PY_W-1:0]  pixel_y;
      logic [COL_W-1:0] pixel_color;
      logic             flush_request;
      logic             last;
      err_type          error_code;
   } rsp_type;

   function automatic logic [REG_AW-1:0] reg_index(input logic [REGF_W-1:0] f);
      logic [6:0] v;
      v = {3'b000, f};
      for (int i = 0; i < 8; i++) begin
         if (v >= 7'(REG_COUNT)) begin
            v = v - 7'(REG_COUNT);
         end
      end
      return REG_AW'(v);
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tiex_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tiex_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [tiex_pkg::FUNC_W-1:0]   req_func,
   input  logic [tiex_pkg::REGF_W-1:0]   req_dest_reg,
   input  logic [tiex_pkg::REGF_W-1:0]   req_src_a_reg,
   input  logic [tiex_pkg::REGF_W-1:0]   req_src_b_reg,
   input  logic signed [tiex_pkg::IMM_W-1:0] req_immediate,
   input  logic [tiex_pkg::PC_W-1:0]     req_alt_target,
   input  logic [tiex_pkg::RND_W-1:0]    req_random_value,
   input  logic                          deq,
   output logic                          q_valid,
   output tiex_pkg::dec_type             q_item
);
   import tiex_pkg::*;

   dec_type           qmem [QUEUE_DEPTH];
   logic [Q_PW-1:0]   wp_ff;
   logic [Q_PW-1:0]   rp_ff;
   logic [Q_CW-1:0]   cnt_ff;
   dec_type           dec;
   logic              accept;
   logic              take;

   always_comb begin
      dec        = '0;
      dec.op     = op_type'(req_func);
      dec.known  = (req_func <= FUNC_W'(OP_CONDBR));
      dec.rd_idx = reg_index(req_dest_reg);
      dec.imm    = WORD_W'(req_immediate);
      dec.alt    = req_alt_target;
      dec.rnd    = req_random_value;
      if (req_func == FUNC_W'(OP_PIXELS)) begin
         dec.addr0 = REG_AW'(PIX_X_REG);
         dec.addr1 = REG_AW'(PIX_Y_REG);
         dec.addr2 = REG_AW'(PIX_C_REG);
      end else begin
         dec.addr0 = reg_index(req_src_a_reg);
         dec.addr1 = reg_index(req_src_b_reg);
         dec.addr2 = reg_index(req_dest_reg);
      end
   end

   assign full    = (cnt_ff == Q_CW'(QUEUE_DEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_item  = qmem[rp_ff];
   assign accept  = push && !full;
   assign take    = deq && q_valid;

   always_ff @(posedge clock) begin
      if (accept) begin
         qmem[wp_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (accept) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (take) begin
            rp_ff <= rp_ff + 1'b1;
         end
         if (accept && !take) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (take && !accept) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/tiex_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tiex_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  tiex_pkg::dec_type  q_item,
   output logic               deq,
   input  logic               pop,
   output logic               empty,
   output tiex_pkg::rsp_type  rsp_head
);
   import tiex_pkg::*;

   state_type            state_ff;
   state_type            state_in;
   dec_type              cur_ff;

   logic [WORD_W-1:0]    rf [REG_COUNT];
   logic [REG_COUNT-1:0] rf_valid_ff;
   logic [WORD_W-1:0]    rp0_ff;
   logic [WORD_W-1:0]    rp1_ff;
   logic                 rp0_en;
   logic                 rp1_en;
   logic [REG_AW-1:0]    rp0_addr;
   logic                 rf_we;

   logic [WORD_W-1:0]    a_ff;
   logic [WORD_W-1:0]    b_ff;

   logic [PC_W-1:0]      pc_ff;
   logic                 run_ff;
   logic [SP_W-1:0]      sp_ff;
   logic [AP_W-1:0]      ap_ff;
   logic [PC_W-1:0]      stk [STACK_DEPTH];
   logic [WORD_W-1:0]    dmem [DMEM_DEPTH];
   logic [WORD_W-1:0]    mem_q_ff;

   logic [1:0]           mcnt_ff;
   logic [DCNT_W-1:0]    dcnt_ff;
   logic [RUN_W-1:0]     pcnt_ff;

   rsp_type              rsp_ff;
   logic                 wen_ff;
   logic [WORD_W-1:0]    wdata_ff;
   logic [PX_W-1:0]      px_ff;
   logic [PY_W-1:0]      py_ff;
   logic [COL_W-1:0]     pcol_ff;

   logic [WORD_W-1:0]    quo_ff;
   logic [WORD_W-1:0]    rem_ff;
   logic [WORD_W-1:0]    dvs_ff;
   logic                 is_rem_ff;
   logic [WORD_W:0]      div_sh;
   logic                 div_ge;
   logic [WORD_W-1:0]    div_rem;
   logic [WORD_W-1:0]    div_quo;

   logic [WORD_W-1:0]    prod_ff;
   logic [WORD_W-1:0]    acc_ff;
   logic [HALF_W-1:0]    mul_x;
   logic [HALF_W-1:0]    mul_y;
   logic [WORD_W-1:0]    mul_p;

   logic [WORD_W-1:0]    c_val;
   logic [PC_W-1:0]      npc_inc;
   logic [WORD_W-1:0]    mem_addr;
   logic                 mem_ok;
   logic [WORD_W-1:0]    room;
   logic [PC_W-1:0]      ex_npc;
   logic                 ex_run;
   err_type              ex_err;
   logic                 ex_flush;
   logic                 ex_wen;
   logic [WORD_W-1:0]    ex_wdata;
   logic [SP_W-1:0]      ex_sp;
   logic [AP_W-1:0]      ex_ap;
   logic                 ex_push;
   logic                 ex_st;
   state_type            ex_next;
   logic [WORD_W-1:0]    ex_dvs;

   rsp_type              omem [QUEUE_DEPTH];
   logic [Q_PW-1:0]      owp_ff;
   logic [Q_PW-1:0]      orp_ff;
   logic [Q_CW-1:0]      ocnt_ff;
   logic                 ofull;
   logic                 opush;
   logic                 otake;
   rsp_type              opush_data;
   rsp_type              pix_rsp;

   // execute stage
   assign c_val    = rp0_ff;
   assign npc_inc  = pc_ff + 1'b1;
   assign mem_addr = a_ff + b_ff;
   assign mem_ok   = (mem_addr < WORD_W'(DMEM_DEPTH));
   assign room     = WORD_W'(DMEM_DEPTH) - WORD_W'(ap_ff);

   always_comb begin
      ex_npc   = npc_inc;
      ex_run   = run_ff;
      ex_err   = ERR_NONE;
      ex_flush = 1'b0;
      ex_wen   = 1'b0;
      ex_wdata = '0;
      ex_sp    = sp_ff;
      ex_ap    = ap_ff;
      ex_push  = 1'b0;
      ex_st    = 1'b0;
      ex_next  = ST_DONE;
      ex_dvs   = cur_ff.imm;
      if (!run_ff) begin
         ex_npc = pc_ff;
      end else if (cur_ff.known) begin
         unique case (cur_ff.op)
            OP_RET: begin
               if (sp_ff == '0) begin
                  ex_run = 1'b0;
               end else begin
                  ex_sp  = sp_ff - 1'b1;
                  ex_npc = stk[ex_sp[STACK_AW-1:0]];
               end
            end
            OP_PIXELS: begin
               if (a_ff > WORD_W'(SCREEN_WIDTH - PIXEL_RUN) ||
                   b_ff >= WORD_W'(SCREEN_HEIGHT)) begin
                  ex_err = ERR_PIXEL;
               end else begin
                  ex_next = ST_PIXEL;
               end
            end
            OP_FLUSH: ex_flush = 1'b1;
            OP_JMP:   ex_npc = cur_ff.imm[PC_W-1:0];
            OP_CALL: begin
               if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                  ex_err = ERR_STACK;
               end else begin
                  ex_push = 1'b1;
                  ex_sp   = sp_ff + 1'b1;
                  ex_npc  = cur_ff.imm[PC_W-1:0];
               end
            end
            OP_RAND: begin
               ex_wen   = 1'b1;
               ex_wdata = WORD_W'(cur_ff.rnd);
            end
            OP_MV: begin
               ex_wen   = 1'b1;
               ex_wdata = a_ff;
            end
            OP_MVI: begin
               ex_wen   = 1'b1;
               ex_wdata = cur_ff.imm;
            end
            OP_ALLOCA: begin
               if (cur_ff.imm > room) begin
                  ex_err = ERR_MEM;
               end else begin
                  ex_wen   = 1'b1;
                  ex_wdata = WORD_W'(ap_ff);
                  ex_ap    = ap_ff + cur_ff.imm[AP_W-1:0];
               end
            end
            OP_ADD: begin
               ex_wen   = 1'b1;
               ex_wdata = a_ff + b_ff;
            end
            OP_SUB: begin
               ex_wen   = 1'b1;
               ex_wdata = a_ff - b_ff;
            end
            OP_DIV: begin
               ex_dvs = b_ff;
               if (b_ff == '0) begin
                  ex_err = ERR_DIV_ZERO;
               end else begin
                  ex_wen  = 1'b1;
                  ex_next = ST_DIV;
               end
            end
            OP_OR: begin
               ex_wen   = 1'b1;
               ex_wdata = a_ff | b_ff;
            end
            OP_ADDI: begin
               ex_wen   = 1'b1;
               ex_wdata = a_ff + cur_ff.imm;
            end
            OP_MULI: begin
               ex_wen  = 1'b1;
               ex_next = ST_MUL;
            end
            OP_REMI: begin
               if (cur_ff.imm == '0) begin
                  ex_err = ERR_DIV_ZERO;
               end else begin
                  ex_wen  = 1'b1;
                  ex_next = ST_DIV;
               end
            end
            OP_ANDI: begin
               ex_wen   = 1'b1;
               ex_wdata = a_ff & cur_ff.imm;
            end
            OP_SLI: begin
               ex_wen = 1'b1;
               if (cur_ff.imm[WORD_W-1:6] != '0) begin
                  ex_wdata = '0;
               end else begin
                  ex_wdata = a_ff << cur_ff.imm[5:0];
               end
            end
            OP_LOAD: begin
               if (!mem_ok) begin
                  ex_err = ERR_MEM;
               end else begin
                  ex_wen  = 1'b1;
                  ex_next = ST_MEMRD;
               end
            end
            OP_STORE: begin
               if (!mem_ok) begin
                  ex_err = ERR_MEM;
               end else begin
                  ex_st = 1'b1;
               end
            end
            OP_ICMPGE: begin
               ex_wen   = 1'b1;
               ex_wdata = WORD_W'(a_ff >= b_ff);
            end
            OP_ICMPNE: begin
               ex_wen   = 1'b1;
               ex_wdata = WORD_W'(a_ff != b_ff);
            end
            OP_CONDBR: ex_npc = (c_val != '0) ? cur_ff.imm[PC_W-1:0] : cur_ff.alt;
            default: ;
         endcase
      end
   end

   // restoring divider, one quotient bit a cycle
   always_comb begin
      div_sh  = {rem_ff, quo_ff[WORD_W-1]};
      div_ge  = (div_sh >= {1'b0, dvs_ff});
      div_rem = div_ge ? WORD_W'(div_sh - {1'b0, dvs_ff}) : div_sh[WORD_W-1:0];
      div_quo = {quo_ff[WORD_W-2:0], div_ge};
   end

   // shared 32x32 multiplier, three partial products
   assign mul_x = (mcnt_ff == 2'd1) ? a_ff[WORD_W-1:HALF_W] : a_ff[HALF_W-1:0];
   assign mul_y = (mcnt_ff == 2'd2) ? cur_ff.imm[WORD_W-1:HALF_W] : cur_ff.imm[HALF_W-1:0];
   assign mul_p = WORD_W'(mul_x) * WORD_W'(mul_y);

   always_comb begin
      pix_rsp               = '0;
      pix_rsp.next_pc       = pc_ff;
      pix_rsp.running       = 1'b1;
      pix_rsp.pixel_valid   = 1'b1;
      pix_rsp.pixel_x       = px_ff + PX_W'(pcnt_ff);
      pix_rsp.pixel_y       = py_ff;
      pix_rsp.pixel_color   = pcol_ff;
      pix_rsp.last          = (pcnt_ff == RUN_W'(PIXEL_RUN - 1));
      pix_rsp.error_code    = ERR_NONE;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (q_valid) state_in = ST_READ;
         ST_READ:  state_in = ST_EXEC;
         ST_EXEC:  state_in = ex_next;
         ST_MUL:   if (mcnt_ff == 2'(MUL_LAST)) state_in = ST_DONE;
         ST_DIV:   if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) state_in = ST_DONE;
         ST_MEMRD: state_in = ST_DONE;
         ST_DONE:  if (!ofull) state_in = ST_IDLE;
         ST_PIXEL: if (!ofull && pix_rsp.last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      deq        = (state_ff == ST_IDLE) && q_valid;
      rp0_en     = deq || (state_ff == ST_READ);
      rp0_addr   = (state_ff == ST_IDLE) ? q_item.addr0 : cur_ff.addr2;
      rp1_en     = deq;
      opush      = ((state_ff == ST_DONE) || (state_ff == ST_PIXEL)) && !ofull;
      opush_data = (state_ff == ST_PIXEL) ? pix_rsp : rsp_ff;
      rf_we      = (state_ff == ST_DONE) && !ofull && wen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= PC_W'(1);
         run_ff   <= 1'b1;
         sp_ff    <= '0;
         ap_ff    <= '0;
         mcnt_ff  <= '0;
         dcnt_ff  <= '0;
         pcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EXEC) begin
            pc_ff   <= ex_npc;
            run_ff  <= ex_run;
            sp_ff   <= ex_sp;
            ap_ff   <= ex_ap;
            mcnt_ff <= '0;
            dcnt_ff <= '0;
            pcnt_ff <= '0;
         end
         if (state_ff == ST_MUL) begin
            mcnt_ff <= mcnt_ff + 1'b1;
         end
         if (state_ff == ST_DIV) begin
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         if (state_ff == ST_PIXEL && !ofull) begin
            pcnt_ff <= pcnt_ff + 1'b1;
         end
      end
   end

   // register file: flop valid bits give the all-zero reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (rf_we) begin
         rf_valid_ff[cur_ff.rd_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf[cur_ff.rd_idx] <= wdata_ff;
      end
      if (rp0_en) begin
         rp0_ff <= rf_valid_ff[rp0_addr] ? rf[rp0_addr] : '0;
      end
      if (rp1_en) begin
         rp1_ff <= rf_valid_ff[q_item.addr1] ? rf[q_item.addr1] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC && ex_st) begin
         dmem[mem_addr[DMEM_AW-1:0]] <= c_val;
      end
      if (state_ff == ST_EXEC) begin
         mem_q_ff <= dmem[mem_addr[DMEM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC && ex_push) begin
         stk[sp_ff[STACK_AW-1:0]] <= npc_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (deq) begin
         cur_ff <= q_item;
      end
      if (state_ff == ST_READ) begin
         a_ff <= rp0_ff;
         b_ff <= rp1_ff;
      end
      if (state_ff == ST_EXEC) begin
         rsp_ff.next_pc       <= ex_npc;
         rsp_ff.running       <= ex_run;
         rsp_ff.pixel_valid   <= 1'b0;
         rsp_ff.pixel_x       <= '0;
         rsp_ff.pixel_y       <= '0;
         rsp_ff.pixel_color   <= '0;
         rsp_ff.flush_request <= ex_flush;
         rsp_ff.last          <= 1'b1;
         rsp_ff.error_code    <= ex_err;
         wen_ff               <= ex_wen;
         wdata_ff             <= ex_wdata;
         px_ff                <= a_ff[PX_W-1:0];
         py_ff                <= b_ff[PY_W-1:0];
         pcol_ff              <= c_val[COL_W-1:0];
         quo_ff               <= a_ff;
         rem_ff               <= '0;
         dvs_ff               <= ex_dvs;
         is_rem_ff            <= (cur_ff.op == OP_REMI);
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= mul_p;
         unique case (mcnt_ff)
            2'd0: acc_ff <= '0;
            2'd1: acc_ff <= prod_ff;
            2'd2: acc_ff <= acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
            2'd3: wdata_ff <= acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
            default: ;
         endcase
      end
      if (state_ff == ST_DIV) begin
         quo_ff <= div_quo;
         rem_ff <= div_rem;
         if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
            wdata_ff <= is_rem_ff ? div_rem : div_quo;
         end
      end
      if (state_ff == ST_MEMRD) begin
         wdata_ff <= mem_q_ff;
      end
   end

   // result queue
   assign ofull    = (ocnt_ff == Q_CW'(QUEUE_DEPTH));
   assign empty    = (ocnt_ff == '0);
   assign otake    = pop && !empty;
   assign rsp_head = omem[orp_ff];

   always_ff @(posedge clock) begin
      if (opush) begin
         omem[owp_ff] <= opush_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (opush) begin
            owp_ff <= owp_ff + 1'b1;
         end
         if (otake) begin
            orp_ff <= orp_ff + 1'b1;
         end
         if (opush && !otake) begin
            ocnt_ff <= ocnt_ff + 1'b1;
         end else if (otake && !opush) begin
            ocnt_ff <= ocnt_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/toy_isa_execute_unit_top.sv -----
// channel   dir  handshake            payload
// req       in   push / full          req_func .. req_random_value
// rsp       out  empty / pop          rsp_next_pc .. rsp_error_code
//
// an instruction passes through the execute sequencer states idle, read, execute and done (pixel for a run);
// immediate multiply adds a multiply state (three 32x32 partial products on one multiplier),
// divide and remainder add a divide state (one quotient bit per cycle), load a memory-read state
// (data memory read port), and a pixel run emits 14 beats
// synchronous active-high reset; register file clears through per-entry valid bits
// a two-deep queue sits on each side, so either side can stall on its own
`timescale 1ns / 1ps
`default_nettype none
module toy_isa_execute_unit_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [tiex_pkg::FUNC_W-1:0]    req_func,
   input  logic [tiex_pkg::REGF_W-1:0]    req_dest_reg,
   input  logic [tiex_pkg::REGF_W-1:0]    req_src_a_reg,
   input  logic [tiex_pkg::REGF_W-1:0]    req_src_b_reg,
   input  logic signed [tiex_pkg::IMM_W-1:0] req_immediate,
   input  logic [tiex_pkg::PC_W-1:0]      req_alt_target,
   input  logic [tiex_pkg::RND_W-1:0]     req_random_value,
   output logic                           empty,
   input  logic                           pop,
   output logic [tiex_pkg::PC_W-1:0]      rsp_next_pc,
   output logic                           rsp_running,
   output logic                           rsp_pixel_valid,
   output logic [tiex_pkg::PX_W-1:0]      rsp_pixel_x,
   output logic [tiex_pkg::PY_W-1:0]      rsp_pixel_y,
   output logic [tiex_pkg::COL_W-1:0]     rsp_pixel_color,
   output logic                           rsp_flush_request,
   output logic                           rsp_last,
   output logic [tiex_pkg::ERR_W-1:0]     rsp_error_code
);
   import tiex_pkg::*;

   logic     q_valid;
   dec_type  q_item;
   logic     deq;
   rsp_type  rsp_head;

   tiex_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_func         (req_func),
      .req_dest_reg     (req_dest_reg),
      .req_src_a_reg    (req_src_a_reg),
      .req_src_b_reg    (req_src_b_reg),
      .req_immediate    (req_immediate),
      .req_alt_target   (req_alt_target),
      .req_random_value (req_random_value),
      .deq              (deq),
      .q_valid          (q_valid),
      .q_item           (q_item)
   );

   tiex_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .deq      (deq),
      .pop      (pop),
      .empty    (empty),
      .rsp_head (rsp_head)
   );

   assign rsp_next_pc       = rsp_head.next_pc;
   assign rsp_running       = rsp_head.running;
   assign rsp_pixel_valid   = rsp_head.pixel_valid;
   assign rsp_pixel_x       = rsp_head.pixel_x;
   assign rsp_pixel_y       = rsp_head.pixel_y;
   assign rsp_pixel_color   = rsp_head.pixel_color;
   assign rsp_flush_request = rsp_head.flush_request;
   assign rsp_last          = rsp_head.last;
   assign rsp_error_code    = rsp_head.error_code;

`ifndef NO_ASSERTIONS
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_no_pixel_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_pixel_valid) |->
         (rsp_pixel_x == '0 && rsp_pixel_y == '0 && rsp_pixel_color == '0))
      else $error("pixel fields set on a non-pixel beat");

   a_halted_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_running) |->
         (rsp_error_code == ERR_W'(ERR_NONE) && !rsp_pixel_valid && rsp_last))
      else $error("halted beat carries work");

   a_pixel_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_pixel_valid) |->
         (rsp_running && !rsp_flush_request && rsp_error_code == ERR_W'(ERR_NONE)))
      else $error("pixel beat carries error or flush");
`endif

endmodule
`default_nettype wire
